// ===== sv/vfrc_pkg.sv =====
package vfrc_pkg;

    // field and state widths
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned HEIGHT_W = 10;
    localparam int unsigned COUNT_W  = 20;
    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    // frame size limits and reset geometry
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH    = 11'd1024;
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT   = 10'd512;
    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd320;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 10'd240;
    localparam logic [TOTAL_W-1:0]  RESET_TOTAL  = 20'd76800;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // held byte count in packed 24-bit mode
    localparam logic [PHASE_W-1:0] PHASE_EMPTY = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ONE   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_TWO   = 2'd2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PACKED24     = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

    // 5-bit channel widened to 8 bits by bit replication
    function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

// ===== sv/vram_frame_to_rgba_converter.sv =====
// path: an input transfer reaches its pixel on the output through the input and result
//   registers; a packed 24-bit word that completes no pixel yields no output transfer
// throughput: one word per cycle, limited only by output back-pressure
// reset: synchronous active-low; clears position, byte phase, pixel count and valid flags
//   and loads 15-bit mode, frame_width=320, frame_height=240
module vram_frame_to_rgba_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [vfrc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vfrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // word input
    input  logic                               i_vram_valid,
    output logic                               o_vram_ready,
    input  logic [vfrc_pkg::WORD_W-1:0]        i_vram_word,
    // pixel output
    output logic                               o_pix_valid,
    input  logic                               i_pix_ready,
    output logic [vfrc_pkg::CHAN_W-1:0]        o_red,
    output logic [vfrc_pkg::CHAN_W-1:0]        o_green,
    output logic [vfrc_pkg::CHAN_W-1:0]        o_blue,
    output logic [vfrc_pkg::CHAN_W-1:0]        o_alpha,
    output logic                               o_frame_last,
    output logic                               o_has_content
);

    // configuration registers
    logic                              r_packed24;
    logic [vfrc_pkg::WIDTH_W-1:0]      r_frame_width;
    logic [vfrc_pkg::HEIGHT_W-1:0]     r_frame_height;
    logic [vfrc_pkg::TOTAL_W-1:0]      r_total;

    // position and counting state
    logic [vfrc_pkg::WIDTH_W-1:0]      r_pixel_column, n_pixel_column;
    logic [vfrc_pkg::HEIGHT_W-1:0]     r_row_index, n_row_index;
    logic [vfrc_pkg::PHASE_W-1:0]      r_byte_phase, n_byte_phase;
    logic [vfrc_pkg::WORD_W-1:0]       r_held_bytes, n_held_bytes;
    logic [vfrc_pkg::COUNT_W-1:0]      r_nonblack_count, n_nonblack_count;

    // input register
    logic                              r_in_valid;
    logic [vfrc_pkg::WORD_W-1:0]       r_in_word;

    // result register
    logic                              r_out_valid;
    logic [vfrc_pkg::CHAN_W-1:0]       r_red, r_green, r_blue;
    logic                              r_frame_last, r_has_content;

    logic                              out_free;
    logic                              proc_en;
    logic                              in_xfer;
    logic                              pix_emit;
    logic [vfrc_pkg::CHAN_W-1:0]       n_red, n_green, n_blue;
    logic                              n_frame_last, n_has_content;
    logic [vfrc_pkg::WIDTH_W-1:0]      width_used;
    logic [vfrc_pkg::HEIGHT_W-1:0]     height_used;
    logic                              row_end;
    logic                              frame_end;
    logic [vfrc_pkg::COUNT_W-1:0]      count_inc;
    logic [vfrc_pkg::COUNT_W+4:0]      count_x20;
    logic [vfrc_pkg::CHAN_W-1:0]       word_lo, word_hi;

    // handshake
    assign out_free     = !r_out_valid || i_pix_ready;
    assign proc_en      = r_in_valid && out_free;
    assign o_vram_ready = !r_in_valid || out_free;
    assign in_xfer      = i_vram_valid && o_vram_ready;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packed24     <= 1'b0;
            r_frame_width  <= vfrc_pkg::RESET_WIDTH;
            r_frame_height <= vfrc_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vfrc_pkg::CFG_PACKED24:     r_packed24     <= i_cfg_data[0];
                vfrc_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                vfrc_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[vfrc_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame geometry
    always_comb begin
        if (r_frame_width == '0) begin
            width_used = vfrc_pkg::WIDTH_W'(1);
        end else if (r_frame_width > vfrc_pkg::MAX_WIDTH) begin
            width_used = vfrc_pkg::MAX_WIDTH;
        end else begin
            width_used = r_frame_width;
        end
        if (r_frame_height == '0) begin
            height_used = vfrc_pkg::HEIGHT_W'(1);
        end else if (r_frame_height > vfrc_pkg::MAX_HEIGHT) begin
            height_used = vfrc_pkg::MAX_HEIGHT;
        end else begin
            height_used = r_frame_height;
        end
    end

    // pixels per frame, registered off the configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= vfrc_pkg::RESET_TOTAL;
        end else begin
            r_total <= {{(vfrc_pkg::TOTAL_W-vfrc_pkg::WIDTH_W){1'b0}}, width_used}
                     * {{(vfrc_pkg::TOTAL_W-vfrc_pkg::HEIGHT_W){1'b0}}, height_used};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_vram_ready) begin
            r_in_valid <= i_vram_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_word <= i_vram_word;
        end
    end

    assign word_lo = r_in_word[7:0];
    assign word_hi = r_in_word[15:8];

    // row and frame end of the pixel being emitted
    assign row_end   = ({1'b0, r_pixel_column} + 12'd1) >= {1'b0, width_used};
    assign frame_end = row_end
                    && (({1'b0, r_row_index} + 11'd1) >= {1'b0, height_used});

    // pixel unpacking and state update
    always_comb begin
        n_pixel_column   = r_pixel_column;
        n_row_index      = r_row_index;
        n_byte_phase     = r_byte_phase;
        n_held_bytes     = r_held_bytes;
        n_nonblack_count = r_nonblack_count;
        pix_emit         = 1'b0;
        n_red            = '0;
        n_green          = '0;
        n_blue           = '0;
        n_frame_last     = 1'b0;
        n_has_content    = 1'b0;
        count_inc        = r_nonblack_count;

        if (!r_packed24) begin
            // 15-bit pixel, any held bytes dropped
            pix_emit     = 1'b1;
            n_byte_phase = vfrc_pkg::PHASE_EMPTY;
            n_red        = vfrc_pkg::widen5(r_in_word[4:0]);
            n_green      = vfrc_pkg::widen5(r_in_word[9:5]);
            n_blue       = vfrc_pkg::widen5(r_in_word[14:10]);
        end else begin
            unique case (r_byte_phase)
                vfrc_pkg::PHASE_TWO: begin
                    pix_emit = 1'b1;
                    n_red    = r_held_bytes[7:0];
                    n_green  = r_held_bytes[15:8];
                    n_blue   = word_lo;
                    if (row_end) begin
                        n_held_bytes = '0;
                        n_byte_phase = vfrc_pkg::PHASE_EMPTY;
                    end else begin
                        n_held_bytes = {8'h00, word_hi};
                        n_byte_phase = vfrc_pkg::PHASE_ONE;
                    end
                end
                vfrc_pkg::PHASE_ONE: begin
                    pix_emit     = 1'b1;
                    n_red        = r_held_bytes[7:0];
                    n_green      = word_lo;
                    n_blue       = word_hi;
                    n_held_bytes = '0;
                    n_byte_phase = vfrc_pkg::PHASE_EMPTY;
                end
                default: begin
                    n_held_bytes = r_in_word;
                    n_byte_phase = vfrc_pkg::PHASE_TWO;
                end
            endcase
        end

        // saturating count of non-black pixels
        if (pix_emit && ((n_red | n_green | n_blue) != '0) && (r_nonblack_count != '1)) begin
            count_inc = r_nonblack_count + vfrc_pkg::COUNT_W'(1);
        end

        // count > floor(total/20) is the same as total < 20*count
        count_x20 = {1'b0, count_inc, 4'b0000} + {3'b000, count_inc, 2'b00};

        if (pix_emit) begin
            n_nonblack_count = count_inc;
            if (row_end) begin
                n_pixel_column = '0;
                if (frame_end) begin
                    n_frame_last     = 1'b1;
                    n_has_content    = {5'b00000, r_total} < count_x20;
                    n_nonblack_count = '0;
                    n_row_index      = '0;
                end else begin
                    n_row_index = r_row_index + vfrc_pkg::HEIGHT_W'(1);
                end
            end else begin
                n_pixel_column = r_pixel_column + vfrc_pkg::WIDTH_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_column   <= '0;
            r_row_index      <= '0;
            r_byte_phase     <= vfrc_pkg::PHASE_EMPTY;
            r_held_bytes     <= '0;
            r_nonblack_count <= '0;
        end else if (proc_en) begin
            r_pixel_column   <= n_pixel_column;
            r_row_index      <= n_row_index;
            r_byte_phase     <= n_byte_phase;
            r_held_bytes     <= n_held_bytes;
            r_nonblack_count <= n_nonblack_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && pix_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pix_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && pix_emit) begin
            r_red         <= n_red;
            r_green       <= n_green;
            r_blue        <= n_blue;
            r_frame_last  <= n_frame_last;
            r_has_content <= n_has_content;
        end
    end

    assign o_pix_valid   = r_out_valid;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = vfrc_pkg::ALPHA_OPAQUE;
    assign o_frame_last  = r_frame_last;
    assign o_has_content = r_has_content;

    // content flag only travels with the frame's last pixel
    a_content_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_has_content |-> r_frame_last)
        else $error("has_content set without frame_last");

    // a pending last pixel means the position has wrapped to the frame start
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_last |-> (r_pixel_column == '0) && (r_row_index == '0))
        else $error("frame_last pending with position not at frame start");

    // byte phase never reaches three
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_phase != 2'd3)
        else $error("illegal byte phase");

    // a 15-bit word leaves no bytes held
    a_phase_15bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en && !r_packed24 |=> r_byte_phase == vfrc_pkg::PHASE_EMPTY)
        else $error("byte phase not cleared in 15-bit mode");

endmodule
